[hdl/rgb_to_packed_pixel_converter_assert.svh]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter assertion macros
// Concurrent assertion wrappers shared by the converter modules.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_PACKED_PIXEL_CONVERTER_ASSERT_SVH
`define RGB_TO_PACKED_PIXEL_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define RGBPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RGBPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define RGBPP_ASSERT(label, clk, rst, prop, msg)
`define RGBPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[hdl/rgbpp_pkg.sv]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter package
// Configuration types, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpp_pkg;

   // default upper bound on bytes per packed pixel
   localparam int DEFAULT_MAX_PIXEL_BYTES = 4;

   // register indexes on the configuration port
   localparam logic [2:0] CSR_SHIFT_RED   = 3'd0;
   localparam logic [2:0] CSR_SHIFT_GREEN = 3'd1;
   localparam logic [2:0] CSR_SHIFT_BLUE  = 3'd2;
   localparam logic [2:0] CSR_BITS_RED    = 3'd3;
   localparam logic [2:0] CSR_BITS_GREEN  = 3'd4;
   localparam logic [2:0] CSR_BITS_BLUE   = 3'd5;
   localparam logic [2:0] CSR_PIXEL_BYTES = 3'd6;

   // configuration register set
   typedef struct packed {
      logic [4:0] shift_red;
      logic [4:0] shift_green;
      logic [4:0] shift_blue;
      logic [4:0] bits_red;
      logic [4:0] bits_green;
      logic [4:0] bits_blue;
      logic [2:0] pixel_bytes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      shift_red:   5'd16,
      shift_green: 5'd8,
      shift_blue:  5'd0,
      bits_red:    5'd8,
      bits_green:  5'd8,
      bits_blue:   5'd8,
      pixel_bytes: 3'd4
   };

endpackage

`default_nettype wire

[hdl/rgbpp_csr.sv]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter configuration registers
// Holds field positions, depths and the byte count written over the port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpp_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wen,
   input  wire logic [2:0]        csr_index,
   input  wire logic [4:0]        csr_wdata,
   output rgbpp_pkg::cfg_type     cfg
);
   import rgbpp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the register write; unknown indexes drop the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_SHIFT_RED:   cfg_in.shift_red   = csr_wdata;
            CSR_SHIFT_GREEN: cfg_in.shift_green = csr_wdata;
            CSR_SHIFT_BLUE:  cfg_in.shift_blue  = csr_wdata;
            CSR_BITS_RED:    cfg_in.bits_red    = csr_wdata;
            CSR_BITS_GREEN:  cfg_in.bits_green  = csr_wdata;
            CSR_BITS_BLUE:   cfg_in.bits_blue   = csr_wdata;
            CSR_PIXEL_BYTES: cfg_in.pixel_bytes = csr_wdata[2:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/rgbpp_front.sv]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter front end
// Accepts pixels, rescales each channel and packs the word for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpp_front #(
   parameter int MAX_PIXEL_BYTES = rgbpp_pkg::DEFAULT_MAX_PIXEL_BYTES,
   parameter int IDX_W           = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rgbpp_pkg::cfg_type cfg,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_red,
   input  wire logic [7:0]         req_green,
   input  wire logic [7:0]         req_blue,
   input  wire logic               req_final_pixel,
   input  wire logic               q_full,
   output logic                    q_push,
   output logic [31:0]             q_word,
   output logic [IDX_W-1:0]        q_last_idx,
   output logic                    q_fin
);
   import rgbpp_pkg::*;

   localparam logic [3:0] MAX_CNT = 4'(MAX_PIXEL_BYTES);

   // channel * (2^d - 1) / 255, split as x * Q + x * R / 255 where
   // Q is a byte repunit shifted by d mod 8 and R = 2^(d mod 8) - 1
   function automatic logic [30:0] rescale(input logic [7:0] x, input logic [4:0] d);
      logic [23:0] rep;
      logic [30:0] hi;
      logic [14:0] v;
      logic [15:0] t;
      case (d[4:3])
         2'd0:    rep = 24'd0;
         2'd1:    rep = {16'd0, x};
         2'd2:    rep = {8'd0, x, x};
         default: rep = {x, x, x};
      endcase
      hi = {7'd0, rep} << d[2:0];
      v  = ({7'd0, x} << d[2:0]) - {7'd0, x};
      // floor(v / 255) for v below 2^15
      t  = {1'b0, v} + 16'd1 + {9'd0, v[14:8]};
      return hi + {23'd0, t[15:8]};
   endfunction

   logic        valid_ff;
   logic        valid_in;
   logic [30:0] red_ff;
   logic [30:0] green_ff;
   logic [30:0] blue_ff;
   logic        fin_ff;
   logic        load;
   logic [3:0]  cnt;
   logic [3:0]  last4;

   // advance the stage when it is empty or its contents move to the queue
   assign q_push    = valid_ff && !q_full;
   assign load      = !valid_ff || !q_full;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture the rescaled channels
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         red_ff   <= rescale(req_red,   cfg.bits_red);
         green_ff <= rescale(req_green, cfg.bits_green);
         blue_ff  <= rescale(req_blue,  cfg.bits_blue);
         fin_ff   <= req_final_pixel;
      end
   end

   // place the fields and keep the low 32 bits
   assign q_word = ({1'b0, red_ff}   << cfg.shift_red)
                 | ({1'b0, green_ff} << cfg.shift_green)
                 | ({1'b0, blue_ff}  << cfg.shift_blue);
   assign q_fin  = fin_ff;

   // bytes per pixel: zero counts as one, saturate at the maximum
   always_comb begin
      if (cfg.pixel_bytes == 3'd0) begin
         cnt = 4'd1;
      end else if ({1'b0, cfg.pixel_bytes} > MAX_CNT) begin
         cnt = MAX_CNT;
      end else begin
         cnt = {1'b0, cfg.pixel_bytes};
      end
   end

   assign last4      = cnt - 4'd1;
   assign q_last_idx = last4[IDX_W-1:0];

endmodule

`default_nettype wire

[hdl/rgbpp_queue.sv]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter queue
// Two-entry queue of packed pixels between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpp_queue #(
   parameter int WIDTH = 36
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output logic [WIDTH-1:0]      head
);
`include "rgb_to_packed_pixel_converter_assert.svh"

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RGBPP_ASSERT(a_no_push_full, clock, reset, !(push && full), "push into full queue")
   `RGBPP_ASSERT(a_no_pop_empty, clock, reset, !(pop && empty), "pop from empty queue")
   `RGBPP_ASSERT_NEXT(a_fill, clock, reset, (push && !pop && !empty), full, "queue failed to fill")

endmodule

`default_nettype wire

[hdl/rgbpp_back.sv]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter back end
// Serializes each packed word into bytes, low byte first, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpp_back #(
   parameter int IDX_W = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_valid,
   input  wire logic [31:0]      q_word,
   input  wire logic [IDX_W-1:0] q_last_idx,
   input  wire logic             q_fin,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_pixel_done,
   output logic                  rsp_run_done
);
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       byte_ff;
   logic             pixel_done_ff;
   logic             run_done_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             load;
   logic             issue;
   logic             done;
   logic [2:0]       idx3;
   logic [7:0]       sel_byte;

   assign load  = !rsp_valid_ff || !rsp_stall;
   assign issue = load && q_valid;
   assign done  = (idx_ff == q_last_idx);
   assign q_pop = issue && done;

   // pick the current byte; bytes past the word read as zero
   assign idx3 = 3'(idx_ff);
   always_comb begin
      if (idx3 < 3'd4) begin
         sel_byte = q_word[{idx3[1:0], 3'b000} +: 8];
      end else begin
         sel_byte = 8'd0;
      end
   end

   // step the byte index, restart on the last byte
   always_comb begin
      idx_in = idx_ff;
      if (issue) begin
         idx_in = done ? '0 : idx_ff + 1'b1;
      end
   end

   assign rsp_valid_in = load ? q_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // load the output register on each transfer slot
   always_ff @(posedge clock) begin
      if (issue) begin
         byte_ff       <= sel_byte;
         pixel_done_ff <= done;
         run_done_ff   <= done && q_fin;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_pixel_done = pixel_done_ff;
   assign rsp_run_done   = run_done_ff;

endmodule

`default_nettype wire

[hdl/rgb_to_packed_pixel_converter.sv]
// ----------------------------------------------------------------------------
// RGB to packed pixel converter
// Rescales RGB888 pixels to configured depths, packs them and emits bytes.
// ----------------------------------------------------------------------------
// Each pixel transfer yields pixel_bytes byte transfers (zero counts as one,
// capped at MAX_PIXEL_BYTES), low byte first; the last byte carries
// pixel_done and, for the final pixel, run_done. The one-byte result register
// sets the rate: each pixel goes out as pixel_bytes byte transfers, 1 to
// MAX_PIXEL_BYTES, and the input takes a new pixel every cycle while the
// two-entry queue has room. The first byte passes the rescale stage, the
// queue and the output register, in that order, before it is presented.
// Configuration writes belong to idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_packed_pixel_converter #(
   parameter int MAX_PIXEL_BYTES = rgbpp_pkg::DEFAULT_MAX_PIXEL_BYTES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wen,
   input  wire logic [2:0] csr_index,
   input  wire logic [4:0] csr_wdata,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   input  wire logic       req_final_pixel,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_pixel_done,
   output logic            rsp_run_done
);
   import rgbpp_pkg::*;

   localparam int IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int Q_W   = 32 + IDX_W + 1;

   cfg_type          cfg;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   logic [31:0]      push_word;
   logic [IDX_W-1:0] push_last_idx;
   logic             push_fin;
   logic [Q_W-1:0]   q_head;

   rgbpp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rgbpp_front #(
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
      .IDX_W           (IDX_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_final_pixel (req_final_pixel),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_word          (push_word),
      .q_last_idx      (push_last_idx),
      .q_fin           (push_fin)
   );

   rgbpp_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_word, push_last_idx, push_fin}),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   rgbpp_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (!q_empty),
      .q_word         (q_head[Q_W-1 -: 32]),
      .q_last_idx     (q_head[IDX_W:1]),
      .q_fin          (q_head[0]),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_pixel_done (rsp_pixel_done),
      .rsp_run_done   (rsp_run_done)
   );

endmodule

`default_nettype wire
